// File: rtl/goaht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// goaht_pkg: shared constants and types of the grouped hash table.
// Sizes, field widths and the state encoding of the probe sequencer.
// ----------------------------------------------------------------------------
package goaht_pkg;

    localparam int Capacity   = 1024;
    localparam int GroupSlots = 32;
    localparam int SlotW      = $clog2(Capacity);
    localparam int CountW     = 11;
    localparam int KeyW       = 64;
    localparam int ValW       = 64;
    localparam int OpW        = 2;
    localparam int JW         = $clog2(GroupSlots);
    localparam int GroupW     = SlotW + 1;

    localparam logic [OpW-1:0] OpLookup   = 2'd0;
    localparam logic [OpW-1:0] OpInsert   = 2'd1;
    localparam logic [OpW-1:0] OpUpsert   = 2'd2;
    // Unused code; it behaves as a lookup.
    localparam logic [OpW-1:0] OpReserved = 2'd3;

    localparam logic [7:0] CtrlSet = 8'h80;
    localparam int CtrlShift = 56;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TAG   = 6'b000010,
        S_KEY   = 6'b000100,
        S_EMPTY = 6'b001000,
        S_WRITE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

endpackage
`default_nettype wire

// File: rtl/grouped_open_addressing_hash_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_open_addressing_hash_table_core: fixed-size open-addressing table.
// Scans 32-slot groups one slot at a time with one shared compare unit.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         op, key, key_hash, new_value
//  m_axis    out        found, slot_index, stored_value, status
//  cfg       in         load_limit
//
// Control and key memories have registered reads, so each slot is compared
// once its read data is in: one pass over a group for the key, a second for
// the first empty slot. Reset starts a clearing pass over the control bytes
// with no item accepted; a waiting result blocks.
module grouped_open_addressing_hash_table_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] operation, [65:2] key, [129:66] key_hash, [193:130] new_value
    input  wire  [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [0] found, [10:1] slot_index, [74:11] stored_value, [75] status
    output logic [79:0]  m_axis_tdata,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [10:0]  i_cfg_data
);
    localparam int SW = goaht_pkg::SlotW;

    logic [7:0]                  r_ctrl [goaht_pkg::Capacity];
    logic [goaht_pkg::KeyW-1:0]  r_keym [goaht_pkg::Capacity];
    logic [goaht_pkg::ValW-1:0]  r_valm [goaht_pkg::Capacity];

    goaht_pkg::t_state r_state;
    logic [goaht_pkg::OpW-1:0]  r_op;
    logic [goaht_pkg::KeyW-1:0] r_key;
    logic [63:0]                r_hash;
    logic [goaht_pkg::ValW-1:0] r_new;
    logic [SW-1:0]              r_start;
    logic [SW:0]                r_step;
    logic [goaht_pkg::JW-1:0]   r_j;
    logic [goaht_pkg::GroupW-1:0] r_groups;
    logic                       r_rd_ph;
    logic [7:0]                 r_ctrl_q;
    logic [goaht_pkg::KeyW-1:0] r_key_q;
    logic [goaht_pkg::ValW-1:0] r_val_q;
    logic [goaht_pkg::CountW-1:0] r_count;
    logic [goaht_pkg::CountW-1:0] r_limit;
    logic [SW:0]                r_clr;
    logic                       r_hit;
    logic [SW-1:0]              r_slot;
    logic                       r_found, r_status, r_ins, r_wval;
    logic [goaht_pkg::ValW-1:0] r_stored;
    logic                       r_ovalid;

    logic [7:0]  w_tag;
    logic [SW-1:0] w_s;
    logic        w_clearing;
    logic        w_last_j;
    logic [SW:0] w_step_n;

    assign w_tag = r_hash[goaht_pkg::CtrlShift +: 8] | goaht_pkg::CtrlSet;
    assign w_s   = r_start + SW'(r_j);
    assign w_clearing = !r_clr[SW];
    assign w_last_j = (r_j == goaht_pkg::JW'(goaht_pkg::GroupSlots - 1));
    assign w_step_n = r_step + 1'b1;

    assign s_axis_tready = (r_state == goaht_pkg::S_IDLE) && !w_clearing && !r_ovalid;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_status, r_stored, r_slot, r_found};

    // Memories: registered read data, read alongside any write.
    always_ff @(posedge i_clk) begin
        if (w_clearing) begin
            r_ctrl[r_clr[SW-1:0]] <= 8'd0;
        end else if (r_state == goaht_pkg::S_WRITE && r_ins) begin
            r_ctrl[r_slot] <= w_tag;
        end
        r_ctrl_q <= r_ctrl[w_s];
        if (r_state == goaht_pkg::S_WRITE && r_ins) begin
            r_keym[r_slot] <= r_key;
        end
        r_key_q <= r_keym[w_s];
        if (r_state == goaht_pkg::S_WRITE && r_wval) begin
            r_valm[r_slot] <= r_new;
        end
        r_val_q <= r_valm[r_slot];
    end

    // Probe sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= goaht_pkg::S_IDLE;
            r_clr    <= '0;
            r_count  <= '0;
            r_limit  <= 11'd896;
            r_ovalid <= 1'b0;
        end else begin
            if (w_clearing) r_clr <= r_clr + 1'b1;
            if (i_cfg_valid) r_limit <= i_cfg_data;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                goaht_pkg::S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op    <= (s_axis_tdata[1:0] == goaht_pkg::OpReserved)
                                   ? goaht_pkg::OpLookup : s_axis_tdata[1:0];
                        r_key   <= s_axis_tdata[65:2];
                        r_hash  <= s_axis_tdata[129:66];
                        r_new   <= s_axis_tdata[193:130];
                        r_start <= s_axis_tdata[66 +: SW];
                        r_step  <= (SW+1)'(goaht_pkg::GroupSlots);
                        r_j     <= '0;
                        r_groups <= '0;
                        r_rd_ph <= 1'b0;
                        r_state <= goaht_pkg::S_TAG;
                    end
                end
                // Tag and key match pass; each slot's read data is registered before the compare.
                goaht_pkg::S_TAG: begin
                    r_rd_ph <= !r_rd_ph;
                    if (r_rd_ph) begin
                        if (r_ctrl_q == w_tag && r_key_q == r_key) begin
                            r_slot  <= w_s;
                            r_hit   <= 1'b1;
                            r_state <= goaht_pkg::S_KEY;
                        end else if (w_last_j) begin
                            r_j <= '0;
                            r_state <= goaht_pkg::S_EMPTY;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                // Empty-slot pass.
                goaht_pkg::S_EMPTY: begin
                    r_rd_ph <= !r_rd_ph;
                    if (r_rd_ph) begin
                        if (r_ctrl_q == 8'd0) begin
                            r_slot  <= w_s;
                            r_hit   <= 1'b0;
                            r_state <= goaht_pkg::S_KEY;
                        end else if (w_last_j) begin
                            r_j <= '0;
                            if (r_groups == goaht_pkg::GroupW'(goaht_pkg::Capacity - 1)) begin
                                r_slot  <= r_hash[SW-1:0];
                                r_found <= 1'b0;
                                r_stored <= '0;
                                r_status <= (r_op != goaht_pkg::OpLookup);
                                r_ins   <= 1'b0;
                                r_wval  <= 1'b0;
                                r_state <= goaht_pkg::S_WRITE;
                            end else begin
                                r_groups <= r_groups + 1'b1;
                                r_step  <= w_step_n;
                                r_start <= r_start + w_step_n[SW-1:0];
                                r_state <= goaht_pkg::S_TAG;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                // Decide; value read of the chosen slot is settled here.
                goaht_pkg::S_KEY: begin
                    r_rd_ph <= !r_rd_ph;
                    if (r_rd_ph) begin
                        r_state <= goaht_pkg::S_WRITE;
                        if (r_hit) begin
                            r_found  <= 1'b1;
                            r_status <= 1'b0;
                            r_ins    <= 1'b0;
                            r_wval   <= (r_op == goaht_pkg::OpInsert);
                            r_stored <= (r_op == goaht_pkg::OpInsert) ? r_new : r_val_q;
                        end else begin
                            r_found <= 1'b0;
                            if (r_op == goaht_pkg::OpLookup) begin
                                r_status <= 1'b0;
                                r_stored <= '0;
                                r_ins <= 1'b0;
                                r_wval <= 1'b0;
                            end else if (r_count < r_limit) begin
                                r_status <= 1'b0;
                                r_stored <= r_new;
                                r_ins <= 1'b1;
                                r_wval <= 1'b1;
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_status <= 1'b1;
                                r_stored <= '0;
                                r_ins <= 1'b0;
                                r_wval <= 1'b0;
                            end
                        end
                    end
                end
                goaht_pkg::S_WRITE: begin
                    r_state <= goaht_pkg::S_OUT;
                end
                goaht_pkg::S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= goaht_pkg::S_IDLE;
                end
                default: r_state <= goaht_pkg::S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the grouped open-addressing hash table core.
// A software copy of the table predicts every response: found flag, slot,
// stored value and status. Requests are drawn mostly from a pool of keys
// that crowd a few probe groups, with random noise items and operation
// codes. Both stream sides stall at random. The load limit is changed
// between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic                       status;
        logic [goaht_pkg::ValW-1:0] stored;
        logic [9:0]                 slot;
        logic                       found;
    } t_resp;

    // Software copy of the table; it predicts one response per request.
    class table_scoreboard;
        logic [7:0]                 ctrl [goaht_pkg::Capacity];
        logic [goaht_pkg::KeyW-1:0] keys [goaht_pkg::Capacity];
        logic [goaht_pkg::ValW-1:0] vals [goaht_pkg::Capacity];
        int unsigned     entries;
        int unsigned     load_limit;
        t_resp           pending [$];
        int              mismatches;

        function new();
            foreach (ctrl[i]) ctrl[i] = 8'h00;
            entries    = 0;
            load_limit = 896;
            mismatches = 0;
        endfunction

        // Walk the probe groups; 0 hit, 1 empty slot, 2 nothing found.
        function int probe(logic [goaht_pkg::KeyW-1:0] key, logic [63:0] hash,
                           output int unsigned slot);
            logic [7:0]  tag;
            int unsigned start;
            int unsigned step;
            int unsigned s;
            tag   = hash[63:56] | goaht_pkg::CtrlSet;
            start = 32'(hash % goaht_pkg::Capacity);
            step  = goaht_pkg::GroupSlots;
            for (int g = 0; g < goaht_pkg::Capacity; g++) begin
                for (int j = 0; j < goaht_pkg::GroupSlots; j++) begin
                    s = (start + j) % goaht_pkg::Capacity;
                    if (ctrl[s] == tag && keys[s] == key) begin
                        slot = s;
                        return 0;
                    end
                end
                for (int j = 0; j < goaht_pkg::GroupSlots; j++) begin
                    s = (start + j) % goaht_pkg::Capacity;
                    if (ctrl[s] == 8'h00) begin
                        slot = s;
                        return 1;
                    end
                end
                step++;
                start = (start + step) % goaht_pkg::Capacity;
            end
            slot = 32'(hash % goaht_pkg::Capacity);
            return 2;
        endfunction

        // Apply an accepted request to the table and queue its response.
        function void note_request(logic [goaht_pkg::OpW-1:0] op,
                                   logic [goaht_pkg::KeyW-1:0] key,
                                   logic [63:0] hash,
                                   logic [goaht_pkg::ValW-1:0] val);
            int unsigned slot;
            int          outcome;
            t_resp       r;
            outcome = probe(key, hash, slot);
            r = '0;
            r.slot = slot[9:0];
            if (outcome == 0) begin
                r.found = 1'b1;
                if (op == goaht_pkg::OpInsert) vals[slot] = val;
                r.stored = vals[slot];
            end else if (op == goaht_pkg::OpInsert || op == goaht_pkg::OpUpsert) begin
                if (outcome == 1 && entries < load_limit) begin
                    ctrl[slot] = hash[63:56] | goaht_pkg::CtrlSet;
                    keys[slot] = key;
                    vals[slot] = val;
                    entries    = (entries + 1) & 11'h7ff;
                    r.stored   = val;
                end else begin
                    r.status = 1'b1;
                end
            end
            pending.push_back(r);
        endfunction

        // Compare one accepted response with the oldest prediction.
        function void check_response(t_resp got);
            t_resp want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response with nothing pending: %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp/act found %b/%b slot %0d/%0d",
                             want.found, got.found, want.slot, got.slot,
                             " value %h/%h status %b/%b",
                             want.stored, got.stored, want.status, got.status);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [10:0]  i_cfg_data = '0;

    table_scoreboard sb = new();
    bit              steady = 1'b0;
    int unsigned     quiet_cycles = 0;

    localparam int PoolSize   = 200;
    localparam int QuietLimit = 60000;

    logic [goaht_pkg::KeyW-1:0] pool_key  [PoolSize];
    logic [63:0]                pool_hash [PoolSize];

    grouped_open_addressing_hash_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Response side stalls at random except during the steady stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 38);
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata[75:0]);
    end

    // Watchdog over cycles in which no item moves on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, with random gaps before it, and wait for acceptance.
    task automatic send_request(logic [goaht_pkg::OpW-1:0] op,
                                logic [goaht_pkg::KeyW-1:0] key,
                                logic [63:0] hash,
                                logic [goaht_pkg::ValW-1:0] val);
        while (!steady && $urandom_range(99) < 38) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'b0, val, hash, key, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, key, hash, val);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Change the load limit once every response has come back.
    task automatic set_load_limit(logic [10:0] limit);
        while (sb.pending.size() != 0) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.load_limit = limit;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly pool keys that crowd a few groups, some random noise items.
    task automatic random_requests(int count);
        int idx;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 85) begin
                idx = $urandom_range(PoolSize - 1);
                send_request(2'($urandom_range(3)), pool_key[idx], pool_hash[idx],
                             {$urandom, $urandom});
            end else begin
                send_request(2'($urandom_range(3)), {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom});
            end
        end
    endtask

    initial begin
        // Pool keys start in eight hot regions so groups overflow and chain.
        foreach (pool_key[i]) begin
            pool_key[i]  = {$urandom, $urandom};
            pool_hash[i] = {$urandom, $urandom};
            pool_hash[i][9:0] = 10'(($urandom_range(7) * 131 + $urandom_range(7))
                                    % goaht_pkg::Capacity);
            if (i % 5 == 0) pool_hash[i][63:56] = 8'h3c;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // A limit of one: a single entry, then every new key is refused.
        set_load_limit(11'd1);
        send_request(goaht_pkg::OpLookup, 64'h0123, 64'h0, 64'h55);
        send_request(goaht_pkg::OpInsert, 64'h0123, 64'h0, 64'h55);
        send_request(goaht_pkg::OpInsert, 64'h0456, 64'h0, 64'h66);
        send_request(goaht_pkg::OpUpsert, 64'h0789, 64'h0, 64'h77);
        send_request(goaht_pkg::OpLookup, 64'h0123, 64'h0, 64'h0);
        send_request(goaht_pkg::OpReserved, 64'h0123, 64'h0, 64'h0);
        send_request(goaht_pkg::OpInsert, 64'h0123, 64'h0, '1);
        send_request(goaht_pkg::OpUpsert, 64'h0123, 64'h0, 64'h1);

        // Limit equal to the capacity: field extremes, same tag with a different key.
        set_load_limit(11'd1024);
        send_request(goaht_pkg::OpInsert, 64'h0, 64'h0, 64'h0);
        send_request(goaht_pkg::OpInsert, '1, '1, '1);
        send_request(goaht_pkg::OpUpsert, 64'hfffe, '1, 64'h1234);
        send_request(goaht_pkg::OpUpsert, 64'hfffe, '1, 64'h9999);
        send_request(goaht_pkg::OpLookup, 64'h0, 64'h0, '1);
        send_request(goaht_pkg::OpLookup, '1, '1, 64'h0);
        send_request(goaht_pkg::OpReserved, 64'hdead, 64'h00ff_0000_0000_03ff, 64'h0);
        send_request(goaht_pkg::OpInsert, 64'h0, 64'h0, 64'h8000_0000_0000_0001);

        steady = 1'b1;
        random_requests(150);
        steady = 1'b0;
        random_requests(450);

        // Limit below the current count refuses all new keys.
        set_load_limit(11'd40);
        random_requests(250);

        set_load_limit(11'd896);
        random_requests(430);

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: grouped_open_addressing_hash_table_core.f
rtl/goaht_pkg.sv
rtl/grouped_open_addressing_hash_table_core.sv
bench/tb.sv
